// File: hw/rtl/rcdsar_pkg.sv
`default_nettype none

package rcdsar_pkg;

    localparam int unsigned NUM_CHANNELS = 6;
    localparam int unsigned TIME_BITS    = 10;
    localparam int unsigned CNT_BITS     = TIME_BITS + 1;

    localparam int unsigned CFG_IDX_BITS  = 3;
    localparam int unsigned CFG_DATA_BITS = 11;

    localparam int unsigned EMIT_BITS    = 10;
    localparam int unsigned CHARGE_BITS  = 8;
    localparam int unsigned TIMEOUT_BITS = 11;
    localparam int unsigned OFF_BITS     = 10;

    typedef logic [TIME_BITS-1:0]     t_capture;
    typedef logic [CNT_BITS-1:0]      t_count;
    typedef logic [CFG_IDX_BITS-1:0]  t_cfg_index;

    localparam t_cfg_index REG_EMIT_SETTLE = 3'd0;
    localparam t_cfg_index REG_CHARGE      = 3'd1;
    localparam t_cfg_index REG_TIMEOUT     = 3'd2;
    localparam t_cfg_index REG_OFF_SETTLE  = 3'd3;

    localparam logic [EMIT_BITS-1:0]    RST_EMIT_SETTLE = 10'd200;
    localparam logic [CHARGE_BITS-1:0]  RST_CHARGE      = 8'd10;
    localparam logic [TIMEOUT_BITS-1:0] RST_TIMEOUT     = 11'd1024;
    localparam logic [OFF_BITS-1:0]     RST_OFF_SETTLE  = 10'd200;

    localparam t_capture CAP_MAX    = {TIME_BITS{1'b1}};
    localparam t_count   WINDOW_MAX = t_count'(1) << TIME_BITS;

endpackage

`default_nettype wire

// File: hw/rtl/rc_discharge_sensor_array_reader.sv
`default_nettype none

// Reads six RC-discharge reflectance sensors. Every input beat is one timing tick (func=1
// also requests a read while idle) and yields exactly one registered result beat showing
// the state after that tick. A tick is taken every clock cycle; input is only held off
// while a result beat waits unaccepted in the output register. A read walks emitter settle,
// charge, measure (each channel latches the first count at which its line is low, preset
// to the clamped window minus one) and off settle, with done pulsing on the final tick.
// Configuration writes are always accepted; indexes beyond 3 are ignored.
module rc_discharge_sensor_array_reader (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_func,
    input  wire logic [5:0]  i_line_levels,

    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_emitter_on,
    output logic             o_charge_lines,
    output logic             o_busy_res,
    output logic             o_done_res,
    output logic [9:0]       o_capture_0,
    output logic [9:0]       o_capture_1,
    output logic [9:0]       o_capture_2,
    output logic [9:0]       o_capture_3,
    output logic [9:0]       o_capture_4,
    output logic [9:0]       o_capture_5,

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [rcdsar_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [rcdsar_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_EMIT,
        PH_CHARGE,
        PH_MEASURE,
        PH_OFF
    } t_phase;

    t_phase                r_phase, n_phase;
    rcdsar_pkg::t_count    r_cnt, n_cnt;
    rcdsar_pkg::t_capture  r_cap [rcdsar_pkg::NUM_CHANNELS];
    rcdsar_pkg::t_capture  n_cap [rcdsar_pkg::NUM_CHANNELS];
    logic                  r_done, n_done;
    logic                  r_out_valid;

    logic [rcdsar_pkg::EMIT_BITS-1:0]    r_emit_settle;
    logic [rcdsar_pkg::CHARGE_BITS-1:0]  r_charge;
    logic [rcdsar_pkg::TIMEOUT_BITS-1:0] r_timeout;
    logic [rcdsar_pkg::OFF_BITS-1:0]     r_off_settle;

    logic                  in_accept;
    logic [rcdsar_pkg::CNT_BITS:0]  cnt_inc;
    rcdsar_pkg::t_count    eff_timeout;
    rcdsar_pkg::t_count    eff_charge;
    rcdsar_pkg::t_capture  preset;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;

    // zero means one tick, longer windows saturate at 2^TIME_BITS
    always_comb begin
        if (r_timeout == '0) begin
            eff_timeout = rcdsar_pkg::t_count'(1);
        end else if (r_timeout > rcdsar_pkg::WINDOW_MAX) begin
            eff_timeout = rcdsar_pkg::WINDOW_MAX;
        end else begin
            eff_timeout = r_timeout;
        end
        eff_charge = (r_charge == '0) ? rcdsar_pkg::t_count'(1)
                                      : rcdsar_pkg::t_count'(r_charge);
        preset     = rcdsar_pkg::t_capture'(eff_timeout - rcdsar_pkg::t_count'(1));
    end

    assign cnt_inc = {1'b0, r_cnt} + 1'b1;

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        for (int i = 0; i < rcdsar_pkg::NUM_CHANNELS; i++) begin
            n_cap[i] = r_cap[i];
        end

        case (r_phase)
            PH_IDLE: begin
                if (i_func) begin
                    n_cnt = '0;
                    if (r_emit_settle == '0) begin
                        n_phase = PH_CHARGE;
                        for (int i = 0; i < rcdsar_pkg::NUM_CHANNELS; i++) begin
                            n_cap[i] = preset;
                        end
                    end else begin
                        n_phase = PH_EMIT;
                    end
                end
            end
            PH_EMIT: begin
                n_cnt = rcdsar_pkg::t_count'(cnt_inc);
                if (cnt_inc >= {2'b0, r_emit_settle}) begin
                    n_phase = PH_CHARGE;
                    n_cnt   = '0;
                    for (int i = 0; i < rcdsar_pkg::NUM_CHANNELS; i++) begin
                        n_cap[i] = preset;
                    end
                end
            end
            PH_CHARGE: begin
                n_cnt = rcdsar_pkg::t_count'(cnt_inc);
                if (cnt_inc >= {1'b0, eff_charge}) begin
                    n_phase = PH_MEASURE;
                    n_cnt   = '0;
                end
            end
            PH_MEASURE: begin
                // first low sample wins, later ones never compare smaller
                for (int i = 0; i < rcdsar_pkg::NUM_CHANNELS; i++) begin
                    if (!i_line_levels[i] && (r_cnt < {1'b0, r_cap[i]})) begin
                        n_cap[i] = rcdsar_pkg::t_capture'(r_cnt);
                    end
                end
                n_cnt = rcdsar_pkg::t_count'(cnt_inc);
                if (cnt_inc >= {1'b0, eff_timeout}) begin
                    n_cnt = '0;
                    if (r_off_settle == '0) begin
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end else begin
                        n_phase = PH_OFF;
                    end
                end
            end
            PH_OFF: begin
                n_cnt = rcdsar_pkg::t_count'(cnt_inc);
                if (cnt_inc >= {2'b0, r_off_settle}) begin
                    n_phase = PH_IDLE;
                    n_cnt   = '0;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_cnt       <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < rcdsar_pkg::NUM_CHANNELS; i++) begin
                r_cap[i] <= rcdsar_pkg::CAP_MAX;
            end
        end else begin
            if (in_accept) begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
                r_done  <= n_done;
                for (int i = 0; i < rcdsar_pkg::NUM_CHANNELS; i++) begin
                    r_cap[i] <= n_cap[i];
                end
            end
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_settle <= rcdsar_pkg::RST_EMIT_SETTLE;
            r_charge      <= rcdsar_pkg::RST_CHARGE;
            r_timeout     <= rcdsar_pkg::RST_TIMEOUT;
            r_off_settle  <= rcdsar_pkg::RST_OFF_SETTLE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rcdsar_pkg::REG_EMIT_SETTLE: begin
                    r_emit_settle <= i_cfg_data[rcdsar_pkg::EMIT_BITS-1:0];
                end
                rcdsar_pkg::REG_CHARGE: begin
                    r_charge <= i_cfg_data[rcdsar_pkg::CHARGE_BITS-1:0];
                end
                rcdsar_pkg::REG_TIMEOUT: begin
                    r_timeout <= i_cfg_data[rcdsar_pkg::TIMEOUT_BITS-1:0];
                end
                rcdsar_pkg::REG_OFF_SETTLE: begin
                    r_off_settle <= i_cfg_data[rcdsar_pkg::OFF_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // the state only moves on an accepted beat, so it doubles as the result register
    assign o_out_valid    = r_out_valid;
    assign o_emitter_on   = (r_phase == PH_EMIT) || (r_phase == PH_CHARGE)
                         || (r_phase == PH_MEASURE);
    assign o_charge_lines = (r_phase == PH_CHARGE);
    assign o_busy_res     = (r_phase != PH_IDLE);
    assign o_done_res     = r_done;
    assign o_capture_0    = r_cap[0];
    assign o_capture_1    = r_cap[1];
    assign o_capture_2    = r_cap[2];
    assign o_capture_3    = r_cap[3];
    assign o_capture_4    = r_cap[4];
    assign o_capture_5    = r_cap[5];

`ifndef NO_ASSERTIONS
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done_res |-> !o_busy_res)
        else $error("done pulse while still busy");

    a_idle_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_cnt == '0))
        else $error("phase counter nonzero while idle");

    a_state_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> ($stable(r_phase) && $stable(r_cnt)))
        else $error("state advanced while result was stalled");

    a_measure_ends_in_off_or_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_phase == PH_MEASURE)
            |=> (r_phase == PH_MEASURE || r_phase == PH_OFF || r_phase == PH_IDLE))
        else $error("illegal phase after measure");
`endif

endmodule

`default_nettype wire

// File: tb/tb_rc_discharge_sensor_array_reader.sv
`timescale 1ns / 1ps

typedef enum logic [2:0] {
    PHASE_IDLE,
    PHASE_EMIT,
    PHASE_CHARGE,
    PHASE_MEASURE,
    PHASE_OFF
} t_sensor_phase;

typedef struct packed {
    logic                                   emitter_on;
    logic                                   charge_lines;
    logic                                   busy;
    logic                                   done;
    logic [rcdsar_pkg::NUM_CHANNELS-1:0][rcdsar_pkg::TIME_BITS-1:0] caps;
} t_sensor_result;

class capture_board;
    int unsigned          emit_settle;
    int unsigned          charge_len;
    int unsigned          timeout_len;
    int unsigned          off_settle;
    t_sensor_phase        phase;
    int unsigned          phase_count;
    rcdsar_pkg::t_capture capture [rcdsar_pkg::NUM_CHANNELS];
    t_sensor_result       pending_results [$];
    int unsigned          errors;

    function new();
        int i;
        emit_settle = rcdsar_pkg::RST_EMIT_SETTLE;
        charge_len  = rcdsar_pkg::RST_CHARGE;
        timeout_len = rcdsar_pkg::RST_TIMEOUT;
        off_settle  = rcdsar_pkg::RST_OFF_SETTLE;
        phase       = PHASE_IDLE;
        phase_count = 0;
        errors      = 0;
        for (i = 0; i < rcdsar_pkg::NUM_CHANNELS; i++) begin
            capture[i] = rcdsar_pkg::CAP_MAX;
        end
    endfunction

    // measurement window after clamping to 1 .. 2^TIME_BITS
    function int unsigned window();
        if (timeout_len == 0) begin
            return 1;
        end
        if (timeout_len > (1 << rcdsar_pkg::TIME_BITS)) begin
            return 1 << rcdsar_pkg::TIME_BITS;
        end
        return timeout_len;
    endfunction

    function int unsigned pending();
        return pending_results.size();
    endfunction

    function void write_reg(rcdsar_pkg::t_cfg_index idx,
                            logic [rcdsar_pkg::CFG_DATA_BITS-1:0] data);
        case (idx)
            rcdsar_pkg::REG_EMIT_SETTLE: emit_settle = data[rcdsar_pkg::EMIT_BITS-1:0];
            rcdsar_pkg::REG_CHARGE:      charge_len  = data[rcdsar_pkg::CHARGE_BITS-1:0];
            rcdsar_pkg::REG_TIMEOUT:     timeout_len = data[rcdsar_pkg::TIMEOUT_BITS-1:0];
            rcdsar_pkg::REG_OFF_SETTLE:  off_settle  = data[rcdsar_pkg::OFF_BITS-1:0];
            default: ;
        endcase
    endfunction

    function void start_charge();
        int i;
        for (i = 0; i < rcdsar_pkg::NUM_CHANNELS; i++) begin
            capture[i] = rcdsar_pkg::t_capture'(window() - 1);
        end
        phase       = PHASE_CHARGE;
        phase_count = 0;
    endfunction

    function void note_tick(logic req, logic [rcdsar_pkg::NUM_CHANNELS-1:0] lv);
        logic           done_now;
        t_sensor_result exp;
        int             i;
        done_now = 1'b0;
        case (phase)
            PHASE_IDLE: begin
                if (req) begin
                    phase_count = 0;
                    if (emit_settle == 0) begin
                        start_charge();
                    end else begin
                        phase = PHASE_EMIT;
                    end
                end
            end
            PHASE_EMIT: begin
                phase_count += 1;
                if (phase_count >= emit_settle) begin
                    start_charge();
                end
            end
            PHASE_CHARGE: begin
                phase_count += 1;
                if (phase_count >= ((charge_len == 0) ? 1 : charge_len)) begin
                    phase       = PHASE_MEASURE;
                    phase_count = 0;
                end
            end
            PHASE_MEASURE: begin
                for (i = 0; i < rcdsar_pkg::NUM_CHANNELS; i++) begin
                    if (!lv[i] && phase_count < capture[i]) begin
                        capture[i] = rcdsar_pkg::t_capture'(phase_count);
                    end
                end
                phase_count += 1;
                if (phase_count >= window()) begin
                    phase_count = 0;
                    if (off_settle == 0) begin
                        phase    = PHASE_IDLE;
                        done_now = 1'b1;
                    end else begin
                        phase = PHASE_OFF;
                    end
                end
            end
            PHASE_OFF: begin
                phase_count += 1;
                if (phase_count >= off_settle) begin
                    phase       = PHASE_IDLE;
                    phase_count = 0;
                    done_now    = 1'b1;
                end
            end
            default: begin
                phase       = PHASE_IDLE;
                phase_count = 0;
            end
        endcase
        exp.emitter_on   = (phase == PHASE_EMIT) || (phase == PHASE_CHARGE)
                           || (phase == PHASE_MEASURE);
        exp.charge_lines = (phase == PHASE_CHARGE);
        exp.busy         = (phase != PHASE_IDLE);
        exp.done         = done_now;
        for (i = 0; i < rcdsar_pkg::NUM_CHANNELS; i++) begin
            exp.caps[i] = capture[i];
        end
        pending_results.push_back(exp);
    endfunction

    function void compare(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            errors += 1;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    function void check_result(t_sensor_result got);
        t_sensor_result exp;
        int             i;
        if (pending_results.size() == 0) begin
            errors += 1;
            $display("%0t: result beat with nothing expected", $time);
            return;
        end
        exp = pending_results.pop_front();
        compare("emitter_on", exp.emitter_on, got.emitter_on);
        compare("charge_lines", exp.charge_lines, got.charge_lines);
        compare("busy_res", exp.busy, got.busy);
        compare("done_res", exp.done, got.done);
        for (i = 0; i < rcdsar_pkg::NUM_CHANNELS; i++) begin
            compare($sformatf("capture_%0d", i), exp.caps[i], got.caps[i]);
        end
    endfunction
endclass

module tb_rc_discharge_sensor_array_reader;

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 80;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    logic             i_func;
    logic [5:0]       i_line_levels;
    logic             o_out_valid;
    logic             i_out_ready;
    logic             o_emitter_on;
    logic             o_charge_lines;
    logic             o_busy_res;
    logic             o_done_res;
    logic [9:0]       o_capture_0;
    logic [9:0]       o_capture_1;
    logic [9:0]       o_capture_2;
    logic [9:0]       o_capture_3;
    logic [9:0]       o_capture_4;
    logic [9:0]       o_capture_5;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    rcdsar_pkg::t_cfg_index                 i_cfg_index;
    logic [rcdsar_pkg::CFG_DATA_BITS-1:0]   i_cfg_data;

    capture_board   board;
    t_sensor_result seen;
    int unsigned    send_idle_pct;
    int unsigned    recv_idle_pct;
    bit             hold_pending;
    int unsigned    discharge_at [rcdsar_pkg::NUM_CHANNELS];
    int unsigned    quiet_cycles;

    rc_discharge_sensor_array_reader i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_line_levels  (i_line_levels),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_emitter_on   (o_emitter_on),
        .o_charge_lines (o_charge_lines),
        .o_busy_res     (o_busy_res),
        .o_done_res     (o_done_res),
        .o_capture_0    (o_capture_0),
        .o_capture_1    (o_capture_1),
        .o_capture_2    (o_capture_2),
        .o_capture_3    (o_capture_3),
        .o_capture_4    (o_capture_4),
        .o_capture_5    (o_capture_5),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic send_tick(input logic req, input logic [5:0] lv);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_func        <= req;
        i_line_levels <= lv;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_tick(req, lv);
    endtask

    // during measurement each line stays high until its own discharge count,
    // with some noisy beats mixed in
    task automatic pick_tick(output logic req, output logic [5:0] lv);
        int unsigned chance;
        int          i;
        chance = (board.phase == PHASE_IDLE) ? 40 : 8;
        req    = ($urandom_range(0, 99) < chance);
        if (board.phase != PHASE_MEASURE) begin
            for (i = 0; i < rcdsar_pkg::NUM_CHANNELS; i++) begin
                discharge_at[i] = $urandom_range(0, board.window() + 2);
            end
            lv = 6'($urandom_range(0, 63));
        end else if ($urandom_range(0, 9) == 0) begin
            lv = 6'($urandom_range(0, 63));
        end else begin
            for (i = 0; i < rcdsar_pkg::NUM_CHANNELS; i++) begin
                lv[i] = (board.phase_count < discharge_at[i]);
            end
        end
    endtask

    task automatic run_random(input int n);
        logic       req;
        logic [5:0] lv;
        repeat (n) begin
            pick_tick(req, lv);
            send_tick(req, lv);
        end
    endtask

    // finish any read in flight, then drain all result beats
    task automatic settle_block();
        logic       req;
        logic [5:0] lv;
        while (board.phase != PHASE_IDLE) begin
            pick_tick(req, lv);
            send_tick(1'b0, lv);
        end
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_beat(input rcdsar_pkg::t_cfg_index idx,
                            input logic [rcdsar_pkg::CFG_DATA_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    task automatic write_registers(input int unsigned emit, input int unsigned charge,
                                   input int unsigned timeout, input int unsigned off);
        settle_block();
        cfg_beat(rcdsar_pkg::REG_EMIT_SETTLE, emit[rcdsar_pkg::CFG_DATA_BITS-1:0]);
        cfg_beat(rcdsar_pkg::REG_CHARGE, charge[rcdsar_pkg::CFG_DATA_BITS-1:0]);
        cfg_beat(rcdsar_pkg::REG_TIMEOUT, timeout[rcdsar_pkg::CFG_DATA_BITS-1:0]);
        cfg_beat(rcdsar_pkg::REG_OFF_SETTLE, off[rcdsar_pkg::CFG_DATA_BITS-1:0]);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic small_setting_run(input int n);
        write_registers($urandom_range(0, 6), $urandom_range(0, 5),
                        $urandom_range(0, 24), $urandom_range(0, 6));
        run_random(n);
    endtask

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen.emitter_on   = o_emitter_on;
            seen.charge_lines = o_charge_lines;
            seen.busy         = o_busy_res;
            seen.done         = o_done_res;
            seen.caps[0]      = o_capture_0;
            seen.caps[1]      = o_capture_1;
            seen.caps[2]      = o_capture_2;
            seen.caps[3]      = o_capture_3;
            seen.caps[4]      = o_capture_4;
            seen.caps[5]      = o_capture_5;
            board.check_result(seen);
        end
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles += 1;
            end
        end
        $display("rc_discharge_sensor_array_reader regression: fail");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_func        = 1'b0;
        i_line_levels = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = rcdsar_pkg::REG_EMIT_SETTLE;
        i_cfg_data    = '0;
        hold_pending  = 1'b0;
        send_idle_pct = 21;
        recv_idle_pct = 46;
        board         = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset lengths except a timeout above the window, which saturates
        cfg_beat(rcdsar_pkg::REG_TIMEOUT, 11'd2047);
        i_cfg_valid <= 1'b0;
        send_tick(1'b0, 6'h00);
        send_tick(1'b0, 6'h3F);
        send_tick(1'b1, 6'h3F);
        // long receiver stall while the read keeps being fed
        hold_pending = 1'b1;
        settle_block();

        // zero lengths: charge and timeout fall back to one tick
        write_registers(0, 0, 0, 0);
        send_tick(1'b1, 6'h3F);
        send_tick(1'b1, 6'h00);  // request while busy, charge tick does not sample
        send_tick(1'b1, 6'h00);  // measure and done on one tick, request ignored
        send_tick(1'b0, 6'h00);  // captures hold between reads
        send_tick(1'b1, 6'h2A);
        send_tick(1'b0, 6'h15);
        send_tick(1'b1, 6'h3F);  // lines never low
        send_tick(1'b1, 6'h3F);  // restart right after done

        // short phases, two channels discharge, the rest time out
        write_registers(2, 1, 3, 1);
        send_tick(1'b1, 6'h3F);
        send_tick(1'b0, 6'h3F);
        send_tick(1'b0, 6'h3F);
        send_tick(1'b0, 6'h00);
        send_tick(1'b0, 6'h3E);
        send_tick(1'b0, 6'h3C);
        send_tick(1'b0, 6'h3F);
        send_tick(1'b1, 6'h00);

        repeat (3) small_setting_run(30);

        send_idle_pct = 46;
        recv_idle_pct = 21;
        repeat (2) small_setting_run(30);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (2) small_setting_run(30);

        settle_block();
        if (board.errors == 0) begin
            $display("rc_discharge_sensor_array_reader regression: pass");
        end else begin
            $display("rc_discharge_sensor_array_reader regression: fail");
        end
        $finish;
    end

endmodule
